// File: rtl/msart_pkg.sv
// ----------------------------------------------------------------------------
// msart_pkg
// Shared types and constants for the disk-image track decoder: parse phases,
// error codes, the per-byte result record and the register map.
// ----------------------------------------------------------------------------
package msart_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_SECTORS_DEF  = 24;
	localparam int SECTOR_BYTES_DEF = 512;

	// Run marker byte of the coded format
	localparam logic [7:0] RLE_MARK = 8'hE5;

	// Register map: one 32-bit register at byte address 0
	localparam int         PADDR_W     = 3;
	localparam int         PDATA_W     = 32;
	localparam int         SPT_W       = 5;
	localparam logic [SPT_W-1:0] SPT_RESET = 5'd9;
	localparam logic       REG_IDX_SPT = 1'b0;

	// Result field widths
	localparam int VALUE_W  = 8;
	localparam int OFFSET_W = 14;
	localparam int LENGTH_W = 14;

	// Parser phase
	typedef enum logic [2:0] {
		PH_HDR_HI = 3'd0,
		PH_HDR_LO = 3'd1,
		PH_RAW    = 3'd2,
		PH_IDLE   = 3'd3,
		PH_VALUE  = 3'd4,
		PH_CNT_HI = 3'd5,
		PH_CNT_LO = 3'd6,
		PH_DONE   = 3'd7
	} phase_t;

	// Error codes carried with the final item of a track
	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_TOO_BIG   = 3'd1,
		ERR_TRUNC     = 3'd2,
		ERR_RUN_OVF   = 3'd3,
		ERR_LIT_OVF   = 3'd4,
		ERR_SHORT     = 3'd5
	} err_t;

	// One result of the parser for one stored byte
	typedef struct packed {
		logic                emit;
		logic [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
		logic                last;
		err_t                err;
	} res_t;

endpackage

// File: rtl/msart_parse.sv
// ----------------------------------------------------------------------------
// msart_parse
// Track record parser: holds the parse state and turns one stored byte into
// at most one write command, updating the state when the byte is consumed.
// ----------------------------------------------------------------------------
module msart_parse #(
	parameter int TRACK_W = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [7:0]                   byte_in,
	input  logic                         start_in,
	input  logic [TRACK_W-1:0]           want,
	output msart_pkg::res_t              res
);
	import msart_pkg::*;

	localparam int SUM_W = ((TRACK_W > 16) ? TRACK_W : 16) + 1;

	phase_t               phase_q;
	phase_t               phase_eff;
	phase_t               phase_nxt;
	logic [15:0]          packed_q;
	logic [15:0]          consumed_q;
	logic [TRACK_W-1:0]   pos_q;
	logic [7:0]           pend_q;
	logic [7:0]           cnt_hi_q;

	logic [15:0]          hdr_len;
	logic [15:0]          consumed_inc;
	logic [15:0]          cnt;
	logic [TRACK_W-1:0]   pos_inc;
	logic [SUM_W-1:0]     want_w;
	logic [SUM_W-1:0]     len_w;
	logic [SUM_W-1:0]     run_end_w;
	logic                 is_mark;
	logic                 full;
	logic                 mark_trunc;
	logic                 data_done;
	logic                 run_ovf;

	// Shared conditions of the current byte
	assign phase_eff    = start_in ? PH_HDR_HI : phase_q;
	assign hdr_len      = {packed_q[15:8], byte_in};
	assign consumed_inc = consumed_q + 16'd1;
	assign cnt          = {cnt_hi_q, byte_in};
	assign pos_inc      = pos_q + TRACK_W'(1);
	assign want_w       = SUM_W'(want);
	assign len_w        = SUM_W'(hdr_len);
	assign run_end_w    = SUM_W'(pos_q) + SUM_W'(cnt);
	assign is_mark      = (byte_in == RLE_MARK);
	assign full         = (pos_q >= want);
	assign mark_trunc   = (17'(consumed_inc) + 17'd3) > 17'(packed_q);
	assign data_done    = (consumed_inc >= packed_q);
	assign run_ovf      = (run_end_w > want_w);

	// Next phase
	always_comb begin
		phase_nxt = phase_eff;
		case (phase_eff)
			PH_HDR_HI: phase_nxt = PH_HDR_LO;
			PH_HDR_LO: begin
				if (len_w == want_w) begin
					phase_nxt = PH_RAW;
				end else if (len_w > want_w || hdr_len == 16'd0) begin
					phase_nxt = PH_DONE;
				end else begin
					phase_nxt = PH_IDLE;
				end
			end
			PH_RAW: begin
				if (full || pos_inc >= want) begin
					phase_nxt = PH_DONE;
				end
			end
			PH_IDLE: begin
				if (is_mark) begin
					phase_nxt = mark_trunc ? PH_DONE : PH_VALUE;
				end else if (full || data_done) begin
					phase_nxt = PH_DONE;
				end
			end
			PH_VALUE:  phase_nxt = PH_CNT_HI;
			PH_CNT_HI: phase_nxt = PH_CNT_LO;
			PH_CNT_LO: phase_nxt = (run_ovf || data_done) ? PH_DONE : PH_IDLE;
			PH_DONE:   phase_nxt = PH_DONE;
			default:   phase_nxt = PH_DONE;
		endcase
	end

	// Result of this byte
	always_comb begin
		res = '0;
		res.err = ERR_NONE;
		case (phase_eff)
			PH_HDR_LO: begin
				if (len_w != want_w && len_w > want_w) begin
					res.emit = 1'b1;
					res.last = 1'b1;
					res.err  = ERR_TOO_BIG;
				end else if (len_w != want_w && hdr_len == 16'd0) begin
					res.emit = 1'b1;
					res.last = 1'b1;
					res.err  = ERR_SHORT;
				end
			end
			PH_RAW: begin
				res.emit = 1'b1;
				if (full) begin
					res.last = 1'b1;
					res.err  = ERR_LIT_OVF;
				end else begin
					res.value  = byte_in;
					res.offset = OFFSET_W'(pos_q);
					res.length = LENGTH_W'(1);
					res.last   = (pos_inc >= want);
				end
			end
			PH_IDLE: begin
				if (is_mark) begin
					if (mark_trunc) begin
						res.emit = 1'b1;
						res.last = 1'b1;
						res.err  = ERR_TRUNC;
					end
				end else if (full) begin
					res.emit = 1'b1;
					res.last = 1'b1;
					res.err  = ERR_LIT_OVF;
				end else begin
					res.emit   = 1'b1;
					res.value  = byte_in;
					res.offset = OFFSET_W'(pos_q);
					res.length = LENGTH_W'(1);
					res.last   = data_done;
					res.err    = (data_done && pos_inc != want) ? ERR_SHORT : ERR_NONE;
				end
			end
			PH_CNT_LO: begin
				res.emit = 1'b1;
				if (run_ovf) begin
					res.last = 1'b1;
					res.err  = ERR_RUN_OVF;
				end else begin
					// A zero count gives an empty write
					if (cnt != 16'd0) begin
						res.value  = pend_q;
						res.offset = OFFSET_W'(pos_q);
					end
					res.length = LENGTH_W'(cnt);
					res.last   = data_done;
					res.err    = (data_done && run_end_w != want_w) ? ERR_SHORT : ERR_NONE;
				end
			end
			default: res = '0;
		endcase
	end

	// Advance the parse state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR_HI;
			packed_q   <= '0;
			consumed_q <= '0;
			pos_q      <= '0;
			pend_q     <= '0;
			cnt_hi_q   <= '0;
		end else if (go) begin
			phase_q <= phase_nxt;
			case (phase_eff)
				PH_HDR_HI: packed_q <= {byte_in, 8'h00};
				PH_HDR_LO: begin
					packed_q   <= hdr_len;
					consumed_q <= '0;
					pos_q      <= '0;
				end
				PH_RAW: begin
					if (!full) begin
						pos_q <= pos_inc;
					end
				end
				PH_IDLE: begin
					consumed_q <= consumed_inc;
					if (!is_mark && !full) begin
						pos_q <= pos_inc;
					end
				end
				PH_VALUE: begin
					consumed_q <= consumed_inc;
					pend_q     <= byte_in;
				end
				PH_CNT_HI: begin
					consumed_q <= consumed_inc;
					cnt_hi_q   <= byte_in;
				end
				PH_CNT_LO: begin
					consumed_q <= consumed_inc;
					if (!run_ovf) begin
						pos_q <= TRACK_W'(run_end_w);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/msa_rle_track_decoder.sv
// ----------------------------------------------------------------------------
// msa_rle_track_decoder
// Disk-image track decoder: parses one stored track record byte by byte and
// issues buffer write commands, raw or run-length coded.
// ----------------------------------------------------------------------------
// Feed the stored bytes of a track record on the byte channel, with
// track_start high on the first header byte. The decoder takes one byte per
// clock and gives at most one write command per byte on the run channel,
// passing through the input register and then the result register; header
// and marker bytes give no command unless they end the record with an error.
// The byte channel stalls only while a finished command waits in the result
// register and the run channel stalls. track_end marks the last command of a
// record, carrying the error code; after it, bytes are dropped until the next
// track_start. Write sectors_per_track at address 0 only while the decoder is
// idle.
// ----------------------------------------------------------------------------
module msa_rle_track_decoder #(
	parameter int MAX_SECTORS_PER_TRACK = msart_pkg::MAX_SECTORS_DEF,
	parameter int SECTOR_BYTES          = msart_pkg::SECTOR_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// stored byte channel
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  logic [7:0]                      packed_byte,
	input  logic                            track_start,
	// write command channel
	output logic                            run_valid,
	input  logic                            run_stall,
	output logic [msart_pkg::VALUE_W-1:0]   run_value,
	output logic [msart_pkg::OFFSET_W-1:0]  run_offset,
	output logic [msart_pkg::LENGTH_W-1:0]  run_length,
	output logic                            track_end,
	output logic [2:0]                      error_code,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [msart_pkg::PADDR_W-1:0]   paddr,
	input  logic [msart_pkg::PDATA_W-1:0]   pwdata,
	output logic [msart_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);
	import msart_pkg::*;

	localparam int TRACK_W = $clog2(MAX_SECTORS_PER_TRACK * SECTOR_BYTES + 1);
	localparam int SECT_W  = $clog2(MAX_SECTORS_PER_TRACK + 1);
	localparam int CLAMP_W = (SECT_W > SPT_W) ? SECT_W : SPT_W;

	logic [SPT_W-1:0]     spt_q;
	logic [CLAMP_W-1:0]   spt_w;
	logic [CLAMP_W-1:0]   spt_c;
	logic [TRACK_W-1:0]   want;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 start_s1;
	logic                 out_free;
	logic                 go;
	logic                 accept;
	res_t                 res;

	logic                 run_valid_q;
	logic [VALUE_W-1:0]   value_q;
	logic [OFFSET_W-1:0]  offset_q;
	logic [LENGTH_W-1:0]  length_q;
	logic                 end_q;
	err_t                 err_q;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q <= SPT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_IDX_SPT) begin
			spt_q <= pwdata[SPT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_IDX_SPT) begin
			prdata = PDATA_W'(spt_q);
		end
	end

	// Clamp the sector count and form the track size
	always_comb begin
		spt_w = CLAMP_W'(spt_q);
		spt_c = spt_w;
		if (spt_w == '0) begin
			spt_c = CLAMP_W'(1);
		end else if (spt_w > CLAMP_W'(MAX_SECTORS_PER_TRACK)) begin
			spt_c = CLAMP_W'(MAX_SECTORS_PER_TRACK);
		end
	end

	assign want = TRACK_W'(spt_c * SECTOR_BYTES);

	// Handshake: consume the held item when the result register can take it
	assign out_free   = !run_valid_q || !run_stall;
	assign go         = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;
	assign accept     = byte_valid && !byte_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= packed_byte;
			start_s1 <= track_start;
		end
	end

	msart_parse #(
		.TRACK_W (TRACK_W)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.byte_in  (byte_s1),
		.start_in (start_s1),
		.want     (want),
		.res      (res)
	);

	// Result register: hold while stalled, load a new command when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
		end else if (out_free) begin
			run_valid_q <= go && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res.emit) begin
			value_q  <= res.value;
			offset_q <= res.offset;
			length_q <= res.length;
			end_q    <= res.last;
			err_q    <= res.err;
		end
	end

	assign run_valid  = run_valid_q;
	assign run_value  = value_q;
	assign run_offset = offset_q;
	assign run_length = length_q;
	assign track_end  = end_q;
	assign error_code = err_q;

endmodule

// File: bench/tb_msa_rle_track_decoder.sv
// ----------------------------------------------------------------------------
// tb_msa_rle_track_decoder
// Self-checking bench for the disk-image track decoder. Stored track bytes
// are fed under random idle gaps and random stalls of the write command
// channel. Every accepted item runs through a local decoder model whose
// commands are queued and compared, field by field, with what the block
// issues. A short table of hand-checked items comes first. Raw and coded
// tracks under several track sizes follow, among them the register
// extremes and a size change in the middle of a raw track.
// ----------------------------------------------------------------------------
module tb_msa_rle_track_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import msart_pkg::*;

	localparam int MAX_SPT       = MAX_SECTORS_DEF;
	localparam int SECTOR_SIZE   = SECTOR_BYTES_DEF;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam logic [PADDR_W-1:0] SPT_ADDR = PADDR_W'(4 * int'(REG_IDX_SPT));

	// One write command as the run channel carries it
	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
		logic                last;
		err_t                err;
	} run_cmd_t;

	// How a table row is checked
	typedef enum logic [1:0] {
		BY_MODEL,
		GIVEN_NONE,
		GIVEN_RUN
	} check_t;

	typedef struct {
		logic [7:0] data;
		logic       first;
		check_t     chk;
		run_cmd_t   run;
	} dir_row_t;

	localparam run_cmd_t NO_RUN = '0;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                byte_valid  = 1'b0;
	logic                byte_stall;
	logic [7:0]          packed_byte = '0;
	logic                track_start = 1'b0;
	logic                run_valid;
	logic                run_stall   = 1'b0;
	logic [VALUE_W-1:0]  run_value;
	logic [OFFSET_W-1:0] run_offset;
	logic [LENGTH_W-1:0] run_length;
	logic                track_end;
	logic [2:0]          error_code;
	logic                psel        = 1'b0;
	logic                penable     = 1'b0;
	logic                pwrite      = 1'b0;
	logic [PADDR_W-1:0]  paddr       = '0;
	logic [PDATA_W-1:0]  pwdata      = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	msa_rle_track_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.packed_byte (packed_byte),
		.track_start (track_start),
		.run_valid   (run_valid),
		.run_stall   (run_stall),
		.run_value   (run_value),
		.run_offset  (run_offset),
		.run_length  (run_length),
		.track_end   (track_end),
		.error_code  (error_code),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Hand-checked items at the reset track size of 4608 bytes
	dir_row_t dir_rows [26] = '{
		'{8'h00,    1'b0, GIVEN_NONE, NO_RUN},
		'{8'h00,    1'b0, GIVEN_RUN,  '{8'h00, 14'd0, 14'd0, 1'b1, ERR_SHORT}},
		'{8'hAB,    1'b0, GIVEN_NONE, NO_RUN},
		'{8'hFF,    1'b1, GIVEN_NONE, NO_RUN},
		'{8'hFF,    1'b0, GIVEN_RUN,  '{8'h00, 14'd0, 14'd0, 1'b1, ERR_TOO_BIG}},
		'{8'h00,    1'b1, GIVEN_NONE, NO_RUN},
		'{8'h0A,    1'b0, GIVEN_NONE, NO_RUN},
		'{8'hFF,    1'b0, GIVEN_RUN,  '{8'hFF, 14'd0, 14'd1, 1'b0, ERR_NONE}},
		'{RLE_MARK, 1'b0, GIVEN_NONE, NO_RUN},
		'{8'h5A,    1'b0, GIVEN_NONE, NO_RUN},
		'{8'h00,    1'b0, GIVEN_NONE, NO_RUN},
		'{8'h00,    1'b0, GIVEN_RUN,  '{8'h00, 14'd0, 14'd0, 1'b0, ERR_NONE}},
		'{RLE_MARK, 1'b0, GIVEN_NONE, NO_RUN},
		'{RLE_MARK, 1'b0, GIVEN_NONE, NO_RUN},
		'{8'h00,    1'b0, GIVEN_NONE, NO_RUN},
		'{8'h03,    1'b0, BY_MODEL,   NO_RUN},
		'{8'h80,    1'b0, GIVEN_RUN,  '{8'h80, 14'd4, 14'd1, 1'b1, ERR_SHORT}},
		'{8'h00,    1'b1, GIVEN_NONE, NO_RUN},
		'{8'h03,    1'b0, GIVEN_NONE, NO_RUN},
		'{RLE_MARK, 1'b0, GIVEN_RUN,  '{8'h00, 14'd0, 14'd0, 1'b1, ERR_TRUNC}},
		'{8'h00,    1'b1, GIVEN_NONE, NO_RUN},
		'{8'h04,    1'b0, GIVEN_NONE, NO_RUN},
		'{RLE_MARK, 1'b0, GIVEN_NONE, NO_RUN},
		'{8'h7F,    1'b0, GIVEN_NONE, NO_RUN},
		'{8'h12,    1'b0, GIVEN_NONE, NO_RUN},
		'{8'h01,    1'b0, GIVEN_RUN,  '{8'h00, 14'd0, 14'd0, 1'b1, ERR_RUN_OVF}}
	};

	// Decoder model state
	phase_t     dec_phase  = PH_HDR_HI;
	logic [4:0] spt_reg    = SPT_RESET;
	int         hdr_len    = 0;
	int         used_bytes = 0;
	int         wr_pos     = 0;
	logic [7:0] run_byte   = '0;
	logic [7:0] cnt_hi     = '0;

	run_cmd_t   pending_runs[$];
	logic [7:0] coded_body[$];
	int         mismatches = 0;
	int         bytes_fed  = 0;
	int         burst_left = 0;
	int         hold_left  = 0;
	int         free_left  = 0;
	int         cycles     = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR: %s", msg);
	endtask

	// Track size with the register clamped to its usable range
	function automatic int track_bytes();
		int s;
		s = int'(spt_reg);
		if (s < 1)
			s = 1;
		if (s > MAX_SPT)
			s = MAX_SPT;
		return s * SECTOR_SIZE;
	endfunction

	function automatic run_cmd_t make_run(input logic [7:0] v, input int off, input int len,
		input logic last, input err_t e);
		run_cmd_t r;
		r.value  = (len == 0) ? 8'h00 : v;
		r.offset = (len == 0) ? '0 : off[OFFSET_W-1:0];
		r.length = len[LENGTH_W-1:0];
		r.last   = last;
		r.err    = e;
		if (last)
			dec_phase = PH_DONE;
		return r;
	endfunction

	// Coded write; the record closes once its last stored byte is used
	function automatic run_cmd_t coded_run(input logic [7:0] v, input int off, input int len);
		if (used_bytes >= hdr_len)
			return make_run(v, off, len, 1'b1,
				(wr_pos == track_bytes()) ? ERR_NONE : ERR_SHORT);
		return make_run(v, off, len, 1'b0, ERR_NONE);
	endfunction

	// Advance the decoder model by one stored byte; 1 when a command results
	function automatic bit track_decode(input logic [7:0] b, input logic s,
		output run_cmd_t r);
		int want;
		int cnt;
		want = track_bytes();
		r = '0;
		if (s)
			dec_phase = PH_HDR_HI;
		case (dec_phase)
			PH_HDR_HI: begin
				hdr_len = int'(b) << 8;
				dec_phase = PH_HDR_LO;
				return 1'b0;
			end
			PH_HDR_LO: begin
				hdr_len = hdr_len | int'(b);
				used_bytes = 0;
				wr_pos = 0;
				if (hdr_len == want) begin
					dec_phase = PH_RAW;
					return 1'b0;
				end
				if (hdr_len > want) begin
					r = make_run(8'h00, 0, 0, 1'b1, ERR_TOO_BIG);
					return 1'b1;
				end
				if (hdr_len == 0) begin
					r = make_run(8'h00, 0, 0, 1'b1, ERR_SHORT);
					return 1'b1;
				end
				dec_phase = PH_IDLE;
				return 1'b0;
			end
			PH_RAW: begin
				if (wr_pos >= want) begin
					r = make_run(8'h00, 0, 0, 1'b1, ERR_LIT_OVF);
					return 1'b1;
				end
				r = make_run(b, wr_pos, 1, (wr_pos + 1 >= want), ERR_NONE);
				wr_pos++;
				return 1'b1;
			end
			PH_IDLE: begin
				used_bytes++;
				if (b == RLE_MARK) begin
					if (used_bytes + 3 > hdr_len) begin
						r = make_run(8'h00, 0, 0, 1'b1, ERR_TRUNC);
						return 1'b1;
					end
					dec_phase = PH_VALUE;
					return 1'b0;
				end
				if (wr_pos >= want) begin
					r = make_run(8'h00, 0, 0, 1'b1, ERR_LIT_OVF);
					return 1'b1;
				end
				wr_pos++;
				r = coded_run(b, wr_pos - 1, 1);
				return 1'b1;
			end
			PH_VALUE: begin
				used_bytes++;
				run_byte = b;
				dec_phase = PH_CNT_HI;
				return 1'b0;
			end
			PH_CNT_HI: begin
				used_bytes++;
				cnt_hi = b;
				dec_phase = PH_CNT_LO;
				return 1'b0;
			end
			PH_CNT_LO: begin
				used_bytes++;
				cnt = int'({cnt_hi, b});
				if (wr_pos + cnt > want) begin
					r = make_run(8'h00, 0, 0, 1'b1, ERR_RUN_OVF);
					return 1'b1;
				end
				dec_phase = PH_IDLE;
				wr_pos += cnt;
				r = coded_run(run_byte, wr_pos - cnt, cnt);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Random byte that is never taken for a run marker
	function automatic logic [7:0] plain_byte();
		logic [7:0] v;
		v = rand_byte();
		return (v == RLE_MARK) ? ~v : v;
	endfunction

	function automatic void add_run(input int cnt);
		coded_body.push_back(RLE_MARK);
		coded_body.push_back(rand_byte());
		coded_body.push_back(8'(cnt >> 8));
		coded_body.push_back(8'(cnt));
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Hand one item to the block, then queue what the model expects
	task automatic feed_byte(input logic [7:0] b, input logic s, input check_t chk,
		input run_cmd_t given);
		int gap;
		bit got;
		run_cmd_t r;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 199) == 0)
				burst_left = $urandom_range(40, 120);
		end
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid  <= 1'b1;
		packed_byte <= b;
		track_start <= s;
		do @(posedge clk); while (byte_stall);
		bytes_fed++;
		got = track_decode(b, s, r);
		if (chk == GIVEN_RUN)
			pending_runs.push_back(given);
		else if (chk == BY_MODEL && got)
			pending_runs.push_back(r);
	endtask

	task automatic feed(input logic [7:0] b, input logic s);
		feed_byte(b, s, BY_MODEL, NO_RUN);
	endtask

	// Drop valid and wait until every queued command has come out
	task automatic settle();
		byte_valid <= 1'b0;
		while (pending_runs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the sector count, then read it back
	task automatic program_sectors(input logic [4:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= SPT_ADDR;
		pwdata  <= PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		spt_reg = val;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(val))
			flag_error($sformatf("sectors_per_track read %0h, written %0h", prdata, val));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic raw_track(input logic [15:0] plen, input int n);
		feed(plen[15:8], 1'b1);
		feed(plen[7:0], 1'b0);
		repeat (n) feed(rand_byte(), 1'b0);
	endtask

	// One record: mostly well-formed coded data, the rest broken or noise
	task automatic random_track(input int want);
		int pick;
		int total;
		int room;
		int cnt;
		int plen;
		int sent;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			feed(8'h00, 1'b1);
			feed(8'h00, 1'b0);
		end else if (pick < 10) begin
			plen = $urandom_range(want + 1, 65535);
			feed(plen[15:8], 1'b1);
			feed(plen[7:0], 1'b0);
		end else if (pick < 13) begin
			// raw record left unfinished, dropped by the next track start
			feed(8'(want >> 8), 1'b1);
			feed(8'(want), 1'b0);
			repeat ($urandom_range(1, 6)) feed(rand_byte(), 1'b0);
		end else if (pick < 18) begin
			repeat ($urandom_range(1, 8)) feed(rand_byte(), ($urandom_range(0, 3) == 0));
		end else begin
			coded_body.delete();
			total = 0;
			repeat ($urandom_range(1, 6)) begin
				room = (want > total) ? want - total : 0;
				if ($urandom_range(0, 2) == 0) begin
					coded_body.push_back(plain_byte());
					total++;
				end else begin
					if ($urandom_range(0, 7) == 0)
						cnt = $urandom_range(0, room);
					else
						cnt = $urandom_range(0, (room < 40) ? room : 40);
					add_run(cnt);
					total += cnt;
				end
			end
			room = (want > total) ? want - total : 0;
			// close the record: exact fill, fill with trailing bytes, short, overflow or cut marker
			case ($urandom_range(0, 9))
				0, 1, 2, 3: if (room > 0) add_run(room);
				4: add_run($urandom_range(0, room));
				5: add_run(room + $urandom_range(1, 3000));
				6: begin
					add_run(room);
					repeat ($urandom_range(1, 2)) coded_body.push_back(plain_byte());
				end
				7: begin
					coded_body.push_back(RLE_MARK);
					repeat ($urandom_range(0, 2)) coded_body.push_back(rand_byte());
				end
				default: ;
			endcase
			plen = coded_body.size();
			if ($urandom_range(0, 9) == 0)
				plen = $urandom_range(1, coded_body.size());
			sent = coded_body.size();
			if ($urandom_range(0, 11) == 0)
				sent = $urandom_range(0, coded_body.size() - 1);
			feed(plen[15:8], 1'b1);
			feed(plen[7:0], 1'b0);
			for (int k = 0; k < sent; k++)
				feed(coded_body[k], 1'b0);
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 3)) feed(rand_byte(), 1'b0);
		end
	endtask

	task automatic coded_phase(input int n);
		int want;
		int stop;
		want = track_bytes();
		stop = bytes_fed + n;
		// stray bytes before any track start carry on the old record
		if ($urandom_range(0, 1) == 1)
			repeat ($urandom_range(1, 3)) feed(rand_byte(), 1'b0);
		// single run filling the whole track
		feed(8'h00, 1'b1);
		feed(8'h04, 1'b0);
		feed(RLE_MARK, 1'b0);
		feed(rand_byte(), 1'b0);
		feed(8'(want >> 8), 1'b0);
		feed(8'(want), 1'b0);
		while (bytes_fed < stop) begin
			if ($urandom_range(0, 39) == 0)
				settle();
			random_track(want);
		end
		settle();
	endtask

	// Stall the command channel: short and long holds, quiet stretches
	always @(posedge clk) begin
		int r;
		if (hold_left > 0) begin
			run_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (free_left > 0) begin
			run_stall <= 1'b0;
			free_left <= free_left - 1;
		end else begin
			r = $urandom_range(0, 99);
			run_stall <= (r >= 60 && r < 97);
			if (r < 60)
				free_left <= $urandom_range(0, 6);
			else if (r < 90)
				hold_left <= $urandom_range(0, 2);
			else if (r < 97)
				hold_left <= $urandom_range(4, 19);
			else
				free_left <= $urandom_range(30, 80);
		end
	end

	// Compare each command taken with the oldest one queued
	always @(posedge clk) begin
		run_cmd_t seen;
		run_cmd_t due;
		if (arst_n && run_valid && !run_stall) begin
			seen = {run_value, run_offset, run_length, track_end, error_code};
			if (pending_runs.size() == 0) begin
				flag_error($sformatf("unexpected command: value %02h offset %0d length %0d %s",
					seen.value, seen.offset, seen.length,
					$sformatf("end %0b err %0d", seen.last, seen.err)));
			end else begin
				due = pending_runs.pop_front();
				if (seen !== due)
					flag_error($sformatf("expected %02h/%0d/%0d/%0b/%0d got %02h/%0d/%0d/%0b/%0d",
						due.value, due.offset, due.length, due.last, due.err,
						seen.value, seen.offset, seen.length, seen.last, seen.err));
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			feed_byte(dir_rows[i].data, dir_rows[i].first, dir_rows[i].chk, dir_rows[i].run);
		settle();

		// full raw track at the smallest size
		program_sectors(5'd1);
		raw_track(16'h0200, SECTOR_SIZE);
		coded_phase(60);

		// raw track left half full, then the size shrinks under it
		program_sectors(5'd2);
		raw_track(16'h0400, SECTOR_SIZE);
		settle();
		program_sectors(5'd1);
		feed(rand_byte(), 1'b0);
		coded_phase(60);

		program_sectors(5'd0);
		coded_phase(60);
		program_sectors(5'd31);
		coded_phase(60);
		program_sectors(5'd24);
		coded_phase(60);
		program_sectors(5'($urandom_range(1, MAX_SPT)));
		coded_phase(60);
		program_sectors(5'($urandom_range(1, MAX_SPT)));
		coded_phase(60);

		settle();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
